FILE: src/knn_pkg.sv
// Shared constants and types of the k-nearest-neighbor classifier.
`default_nettype none
package knn_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int FEATURE_COUNT = 4;
  localparam int FEATURE_BITS  = 16;
  // Squared distance: one square per feature, summed.
  localparam int DIST_W = 2 * FEATURE_BITS + $clog2(FEATURE_COUNT);

  localparam int CFG_W = 4;
  localparam logic [CFG_W-1:0] NEIGHBOURS_RESET = 4'd3;
  localparam logic [CFG_W-1:0] ENTRIES_RESET    = 4'd6;

  // Configuration register indexes.
  localparam logic [0:0] CFG_NEIGHBOURS = 1'b0;
  localparam logic [0:0] CFG_ENTRIES    = 1'b1;

  // Request function codes.
  localparam logic FUNC_LOAD     = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  // Control of the ranking list.
  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } rank_ctl_t;

endpackage
`default_nettype wire

FILE: src/knn_ram.sv
// Generic RAM, one write port and one registered read port.
`default_nettype none
module knn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AW-1:0]            raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: src/knn_lane.sv
// One feature lane: absolute difference, then its square, each registered.
`default_nettype none
module knn_lane #(
  parameter int FEAT_W = knn_pkg::FEATURE_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic [FEAT_W-1:0]     query_i,
  input  wire logic [FEAT_W-1:0]     train_i,
  output logic      [2*FEAT_W-1:0]   sq_o
);
  logic [FEAT_W-1:0]   diff_d, diff_q;
  logic [2*FEAT_W-1:0] sq_q;

  assign diff_d = (query_i >= train_i) ? (query_i - train_i) : (train_i - query_i);

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    sq_q   <= (2*FEAT_W)'(diff_q) * (2*FEAT_W)'(diff_q);
  end

  assign sq_o = sq_q;

endmodule
`default_nettype wire

FILE: src/knn_rank.sv
// Sorted list of nearest entries: parallel insertion, label shift-out for the vote.
`default_nettype none
module knn_rank #(
  parameter int DEPTH  = knn_pkg::TABLE_ENTRIES,
  parameter int DIST_W = knn_pkg::DIST_W
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire knn_pkg::rank_ctl_t ctl_i,
  input  wire logic [DIST_W-1:0] ins_dist_i,
  input  wire logic              ins_label_i,
  output logic      [DIST_W-1:0] head_dist_o,
  output logic                   head_label_o
);
  logic [DIST_W-1:0] dist_q [DEPTH];
  logic [DIST_W-1:0] dist_d [DEPTH];
  logic [DEPTH-1:0]  lab_q, lab_d;
  logic [DEPTH-1:0]  gt;

  // gt[p]: stored entry ranks after the new one (label 0 first on equal distance).
  always_comb begin
    for (int p = 0; p < DEPTH; p++) begin
      gt[p] = (dist_q[p] != ins_dist_i) ? (dist_q[p] > ins_dist_i)
                                        : (lab_q[p] & ~ins_label_i);
    end
  end

  for (genvar p = 0; p < DEPTH; p++) begin : g_cell
    logic              take_new, take_prev;
    logic [DIST_W-1:0] prev_dist;
    logic              prev_lab, up_lab;

    if (p == 0) begin : g_first
      assign take_new  = gt[0];
      assign take_prev = 1'b0;
      assign prev_dist = ins_dist_i;
      assign prev_lab  = ins_label_i;
    end else begin : g_rest
      assign take_new  = gt[p] & ~gt[p-1];
      assign take_prev = gt[p] & gt[p-1];
      assign prev_dist = dist_q[p-1];
      assign prev_lab  = lab_q[p-1];
    end

    if (p == DEPTH-1) begin : g_last
      assign up_lab = 1'b0;
    end else begin : g_mid
      assign up_lab = lab_q[p+1];
    end

    always_comb begin
      dist_d[p] = dist_q[p];
      lab_d[p]  = lab_q[p];
      priority if (ctl_i.clear) begin
        dist_d[p] = '1;
        lab_d[p]  = 1'b0;
      end else if (ctl_i.insert && take_new) begin
        dist_d[p] = ins_dist_i;
        lab_d[p]  = ins_label_i;
      end else if (ctl_i.insert && take_prev) begin
        dist_d[p] = prev_dist;
        lab_d[p]  = prev_lab;
      end else if (ctl_i.shift) begin
        lab_d[p]  = up_lab;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < DEPTH; p++) begin
        dist_q[p] <= '1;
      end
      lab_q <= '0;
    end else begin
      dist_q <= dist_d;
      lab_q  <= lab_d;
    end
  end

  assign head_dist_o  = dist_q[0];
  assign head_label_o = lab_q[0];

endmodule
`default_nettype wire

FILE: src/knn_binary_classifier.sv
// Top level of the k-nearest-neighbor binary classifier.
// Load request: writes one table slot, no result.
// Classify request: done_o strobes after the table walk and the vote (used, k clamped);
//   one table RAM read per cycle, a 4-stage distance pipeline, then one label per vote cycle.
// A new request is taken in the done_o cycle; busy is high from accept until then.
// Reset (rst_ni low, async): idle, registers 3 and 6, ranking list cleared; table undefined.
`default_nettype none
module knn_binary_classifier #(
  parameter int TABLE_ENTRIES = knn_pkg::TABLE_ENTRIES
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // request side
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         func_i,
  input  wire logic [2:0]                   entry_index_i,
  input  wire logic [15:0]                  feature_0_i,
  input  wire logic [15:0]                  feature_1_i,
  input  wire logic [15:0]                  feature_2_i,
  input  wire logic [15:0]                  feature_3_i,
  input  wire logic                         entry_label_i,
  // result side
  output logic                              done_o,
  output logic                              predicted_class_o,
  output logic [3:0]                        class_one_votes_o,
  output logic [33:0]                       nearest_distance_o,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [0:0]                   cfg_idx_i,
  input  wire logic [knn_pkg::CFG_W-1:0]    cfg_wdata_i
);
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int FC = knn_pkg::FEATURE_COUNT;
  localparam int FB = knn_pkg::FEATURE_BITS;
  localparam int RW = FC * FB + 1;
  localparam int DW = knn_pkg::DIST_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_VOTE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [knn_pkg::CFG_W-1:0] cfg_k_q, cfg_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_k_q    <= knn_pkg::NEIGHBOURS_RESET;
      cfg_used_q <= knn_pkg::ENTRIES_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        knn_pkg::CFG_NEIGHBOURS: cfg_k_q    <= cfg_wdata_i;
        knn_pkg::CFG_ENTRIES:    cfg_used_q <= cfg_wdata_i;
      endcase
    end
  end

  // Request decode
  logic req_acc, load_we, cls_go;

  assign busy    = (state_q != ST_IDLE);
  assign req_acc = start & ~busy;
  assign cls_go  = req_acc & (func_i == knn_pkg::FUNC_CLASSIFY);
  // loads to slots past the table are dropped
  assign load_we = req_acc & (func_i == knn_pkg::FUNC_LOAD) &
                   (32'(entry_index_i) < TABLE_ENTRIES);

  // Clamp entry count to 1..TABLE_ENTRIES and k to 1..used
  logic [CW-1:0] used_c, k_c;

  always_comb begin
    int k_raw;
    if (cfg_used_q == '0) begin
      used_c = CW'(1);
    end else if (32'(cfg_used_q) > TABLE_ENTRIES) begin
      used_c = CW'(TABLE_ENTRIES);
    end else begin
      used_c = CW'(cfg_used_q);
    end
    k_raw = (cfg_k_q == '0) ? 1 : 32'(cfg_k_q);
    k_c   = (k_raw > 32'(used_c)) ? used_c : CW'(k_raw);
  end

  // Query latch
  logic [FB-1:0] feat_in [FC];
  logic [FB-1:0] qry_q   [FC];

  assign feat_in[0] = feature_0_i;
  assign feat_in[1] = feature_1_i;
  assign feat_in[2] = feature_2_i;
  assign feat_in[3] = feature_3_i;

  always_ff @(posedge clk_i) begin
    if (cls_go) begin
      qry_q <= feat_in;
    end
  end

  // Per-request clamped counts, latched at the classify accept
  logic [CW-1:0] used_q, used_d, k_q, k_d;

  // Training table: {label, f3, f2, f1, f0}
  logic [CW-1:0] rd_cnt_q, rd_cnt_d;
  logic          rd_en;
  logic [RW-1:0] ram_rdata;

  assign rd_en = (state_q == ST_WALK) && (rd_cnt_q < used_q);

  knn_ram #(
    .WIDTH(RW),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (load_we),
    .waddr_i(AW'(entry_index_i)),
    .wdata_i({entry_label_i, feature_3_i, feature_2_i, feature_1_i, feature_0_i}),
    .re_i   (rd_en),
    .raddr_i(rd_cnt_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // Feature lanes: one squared difference per feature per cycle
  logic [2*FB-1:0] lane_sq [FC];

  for (genvar f = 0; f < FC; f++) begin : g_lane
    knn_lane #(
      .FEAT_W(FB)
    ) u_lane (
      .clk_i  (clk_i),
      .query_i(qry_q[f]),
      .train_i(ram_rdata[f*FB +: FB]),
      .sq_o   (lane_sq[f])
    );
  end

  // Merge stage: sum of the lane squares
  logic [DW-1:0] sum_c, sum_q;

  always_comb begin
    sum_c = '0;
    for (int f = 0; f < FC; f++) begin
      sum_c = sum_c + DW'(lane_sq[f]);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_c;
  end

  // Valid and label track the distance pipeline (RAM, diff, square, sum)
  logic vld1_q, vld2_q, vld3_q, vld4_q;
  logic lab2_q, lab3_q, lab4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= rd_en;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lab2_q <= ram_rdata[RW-1];
    lab3_q <= lab2_q;
    lab4_q <= lab3_q;
  end

  // Ranking list
  knn_pkg::rank_ctl_t rank_ctl;
  logic [DW-1:0]      head_dist;
  logic               head_lab;

  assign rank_ctl.clear  = cls_go;
  assign rank_ctl.insert = vld4_q;
  assign rank_ctl.shift  = (state_q == ST_VOTE);

  knn_rank #(
    .DEPTH (TABLE_ENTRIES),
    .DIST_W(DW)
  ) u_rank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (rank_ctl),
    .ins_dist_i  (sum_q),
    .ins_label_i (lab4_q),
    .head_dist_o (head_dist),
    .head_label_o(head_lab)
  );

  // Sequencer: walk the table, wait for the last insert, then vote
  logic [CW-1:0] ins_cnt_q, ins_cnt_d, vote_cnt_q, vote_cnt_d;
  logic [CW-1:0] ones_q, ones_d, ones_sum;
  logic          done_d, done_q;
  logic          pred_q;
  logic [3:0]    votes_q;
  logic [33:0]   near_q;

  assign ones_sum = ones_q + CW'(head_lab);

  always_comb begin
    state_d    = state_q;
    rd_cnt_d   = rd_cnt_q;
    ins_cnt_d  = ins_cnt_q;
    vote_cnt_d = vote_cnt_q;
    ones_d     = ones_q;
    used_d     = used_q;
    k_d        = k_q;
    done_d     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cls_go) begin
          state_d   = ST_WALK;
          rd_cnt_d  = '0;
          ins_cnt_d = '0;
          used_d    = used_c;
          k_d       = k_c;
        end
      end
      ST_WALK: begin
        if (rd_en) begin
          rd_cnt_d = rd_cnt_q + CW'(1);
        end
        if (vld4_q) begin
          ins_cnt_d = ins_cnt_q + CW'(1);
          if (ins_cnt_q == used_q - CW'(1)) begin
            state_d    = ST_VOTE;
            vote_cnt_d = '0;
            ones_d     = '0;
          end
        end
      end
      ST_VOTE: begin
        ones_d = ones_sum;
        if (vote_cnt_q == k_q - CW'(1)) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end else begin
          vote_cnt_d = vote_cnt_q + CW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_cnt_q   <= '0;
      ins_cnt_q  <= '0;
      vote_cnt_q <= '0;
      ones_q     <= '0;
      used_q     <= CW'(1);
      k_q        <= CW'(1);
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_cnt_q   <= rd_cnt_d;
      ins_cnt_q  <= ins_cnt_d;
      vote_cnt_q <= vote_cnt_d;
      ones_q     <= ones_d;
      used_q     <= used_d;
      k_q        <= k_d;
      done_q     <= done_d;
    end
  end

  // Result registers; a vote tie gives class 1
  always_ff @(posedge clk_i) begin
    if (done_d) begin
      pred_q  <= ((k_q - ones_sum) > ones_sum) ? 1'b0 : 1'b1;
      votes_q <= 4'(ones_sum);
      near_q  <= 34'(head_dist);
    end
  end

  assign done_o             = done_q;
  assign predicted_class_o  = pred_q;
  assign class_one_votes_o  = votes_q;
  assign nearest_distance_o = near_q;

  // Checks
  a_done_from_vote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == ST_VOTE)
    else $error("result strobe without a vote");

  a_insert_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld4_q |-> (state_q == ST_WALK) && (ins_cnt_q < used_q))
    else $error("ranking insert outside the table walk");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !(vld1_q || vld2_q || vld3_q || vld4_q))
    else $error("distance pipeline busy while idle");

  a_vote_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> predicted_class_o == (32'(class_one_votes_o) * 2 >= 32'(k_q)))
    else $error("predicted class does not follow the vote");

endmodule
`default_nettype wire

FILE: tb/knn_binary_classifier_test.sv
// Self-checking testbench of the k-nearest-neighbor binary classifier.
`timescale 1ns / 100ps
module knn_binary_classifier_test;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  // Idle time before a register write or the end.
  localparam int SETTLE_CYCLES  = 24;
  // Cycles without any request, result or register write before giving up.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RAND_PHASES    = 12;
  localparam int PHASE_ITEMS    = 50;

  typedef logic [knn_pkg::FEATURE_COUNT-1:0][knn_pkg::FEATURE_BITS-1:0] feat_vec_t;

  // One entry of the stimulus plan: a request, a register write, or a drain pause.
  typedef enum logic [1:0] {
    STEP_REQUEST,
    STEP_CONFIG,
    STEP_DRAIN
  } step_kind_e;

  typedef struct packed {
    step_kind_e                kind;
    logic                      calm;       // no idle burst in front of this request
    logic                      func;
    logic [2:0]                slot;
    feat_vec_t                 feat;
    logic                      label;
    logic [0:0]                cfg_idx;
    logic [knn_pkg::CFG_W-1:0] cfg_value;
  } plan_step_t;

  // What one classify request must return.
  typedef struct packed {
    logic                       cls;
    logic [3:0]                 votes;
    logic [knn_pkg::DIST_W-1:0] near_dist;
  } verdict_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                      start         = 1'b0;
  logic                      busy;
  logic                      func_i        = knn_pkg::FUNC_LOAD;
  logic [2:0]                entry_index_i = '0;
  logic [15:0]               feature_0_i   = '0;
  logic [15:0]               feature_1_i   = '0;
  logic [15:0]               feature_2_i   = '0;
  logic [15:0]               feature_3_i   = '0;
  logic                      entry_label_i = 1'b0;
  logic                      done_o;
  logic                      predicted_class_o;
  logic [3:0]                class_one_votes_o;
  logic [33:0]               nearest_distance_o;
  logic                      cfg_we_i      = 1'b0;
  logic [0:0]                cfg_idx_i     = knn_pkg::CFG_NEIGHBOURS;
  logic [knn_pkg::CFG_W-1:0] cfg_wdata_i   = '0;

  knn_binary_classifier dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .func_i             (func_i),
    .entry_index_i      (entry_index_i),
    .feature_0_i        (feature_0_i),
    .feature_1_i        (feature_1_i),
    .feature_2_i        (feature_2_i),
    .feature_3_i        (feature_3_i),
    .entry_label_i      (entry_label_i),
    .done_o             (done_o),
    .predicted_class_o  (predicted_class_o),
    .class_one_votes_o  (class_one_votes_o),
    .nearest_distance_o (nearest_distance_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the classifier: training table and both registers.
  // ---------------------------------------------------------------------------
  feat_vec_t                 train_feat  [knn_pkg::TABLE_ENTRIES];
  logic                      train_label [knn_pkg::TABLE_ENTRIES];
  logic [knn_pkg::CFG_W-1:0] neighbours_cfg = knn_pkg::NEIGHBOURS_RESET;
  logic [knn_pkg::CFG_W-1:0] entries_cfg    = knn_pkg::ENTRIES_RESET;

  plan_step_t step_plan[$];     // stimulus not yet presented
  verdict_t   verdicts_due[$];  // classify results still to come, oldest first

  int settle_cnt  = 0;          // cycles with no request pending and the block idle
  int gap_left    = 0;
  logic gap_spent = 1'b0;       // the head request already had its idle burst
  int error_count = 0;
  int quiet_cnt   = 0;

  // Rank the entries in use by squared distance (label 0 first on a tie),
  // then let the nearest ones vote; a tied vote gives class 1.
  function automatic verdict_t classify_query(input feat_vec_t query);
    int unsigned used, k, ones, p;
    logic [knn_pkg::DIST_W-1:0] rank_dist [knn_pkg::TABLE_ENTRIES];
    logic                       rank_lab  [knn_pkg::TABLE_ENTRIES];
    logic [knn_pkg::DIST_W-1:0] d;
    logic [knn_pkg::FEATURE_BITS-1:0] diff;
    verdict_t v;
    used = (entries_cfg == 0) ? 1 : entries_cfg;
    if (used > knn_pkg::TABLE_ENTRIES) used = knn_pkg::TABLE_ENTRIES;
    k = (neighbours_cfg == 0) ? 1 : neighbours_cfg;
    if (k > used) k = used;
    for (int i = 0; i < int'(used); i++) begin
      d = '0;
      for (int f = 0; f < knn_pkg::FEATURE_COUNT; f++) begin
        diff = (query[f] >= train_feat[i][f]) ? query[f] - train_feat[i][f]
                                              : train_feat[i][f] - query[f];
        d = d + knn_pkg::DIST_W'(diff) * knn_pkg::DIST_W'(diff);
      end
      // Insertion into the sorted list; equal distance and label keep table order.
      p = i;
      while (p > 0 && (rank_dist[p-1] > d ||
                       (rank_dist[p-1] == d && rank_lab[p-1] > train_label[i]))) begin
        rank_dist[p] = rank_dist[p-1];
        rank_lab[p]  = rank_lab[p-1];
        p--;
      end
      rank_dist[p] = d;
      rank_lab[p]  = train_label[i];
    end
    ones = 0;
    for (int i = 0; i < int'(k); i++) ones += rank_lab[i];
    v.cls       = ((k - ones) > ones) ? 1'b0 : 1'b1;
    v.votes     = 4'(ones);
    v.near_dist = rank_dist[0];
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Plan building
  // ---------------------------------------------------------------------------
  function automatic feat_vec_t vec4(input logic [15:0] f0, f1, f2, f3);
    return {f3, f2, f1, f0};
  endfunction

  function automatic void add_request(input logic func, input logic [2:0] slot,
                                      input feat_vec_t feat, input logic label,
                                      input logic calm);
    plan_step_t s;
    s           = '0;
    s.kind      = STEP_REQUEST;
    s.calm      = calm;
    s.func      = func;
    s.slot      = slot;
    s.feat      = feat;
    s.label     = label;
    step_plan   = {step_plan, s};
  endfunction

  // Register write or drain pause; both wait for an idle block.
  function automatic void add_control(input step_kind_e kind, input logic [0:0] idx,
                                      input logic [knn_pkg::CFG_W-1:0] value);
    plan_step_t s;
    s           = '0;
    s.kind      = kind;
    s.cfg_idx   = idx;
    s.cfg_value = value;
    step_plan   = {step_plan, s};
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents the head of the plan, predicts at each accepted request.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic taken;
    logic nxt_start;
    logic nxt_we;
    plan_step_t head;
    if (!rst_ni) begin
      start     <= 1'b0;
      cfg_we_i  <= 1'b0;
      settle_cnt = 0;
      gap_left   = 0;
      gap_spent  = 1'b0;
    end else begin
      taken = start && !busy;
      // The ports still hold the request that was just taken.
      if (taken) begin
        if (func_i == knn_pkg::FUNC_LOAD) begin
          if (entry_index_i < knn_pkg::TABLE_ENTRIES) begin
            train_feat[entry_index_i]  = {feature_3_i, feature_2_i, feature_1_i, feature_0_i};
            train_label[entry_index_i] = entry_label_i;
          end
        end else begin
          verdicts_due = {verdicts_due, classify_query(
            {feature_3_i, feature_2_i, feature_1_i, feature_0_i})};
        end
      end

      if (start || busy) settle_cnt = 0;
      else if (settle_cnt < SETTLE_CYCLES) settle_cnt++;

      nxt_start = start && !taken;   // a request not yet taken stays up
      nxt_we    = 1'b0;
      if (!nxt_start) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (step_plan.size() != 0) begin
          head = step_plan[0];
          if (head.kind == STEP_REQUEST) begin
            if (!head.calm && !gap_spent && $urandom_range(0, 3) == 0) begin
              // idle burst in front of the head request, this cycle included
              gap_left  = $urandom_range(0, 16);
              gap_spent = 1'b1;
            end else begin
              func_i        <= head.func;
              entry_index_i <= head.slot;
              feature_0_i   <= head.feat[0];
              feature_1_i   <= head.feat[1];
              feature_2_i   <= head.feat[2];
              feature_3_i   <= head.feat[3];
              entry_label_i <= head.label;
              nxt_start      = 1'b1;
              gap_spent      = 1'b0;
              void'(step_plan.pop_front());
            end
          end else if (settle_cnt >= SETTLE_CYCLES && verdicts_due.size() == 0) begin
            if (head.kind == STEP_CONFIG) begin
              cfg_idx_i   <= head.cfg_idx;
              cfg_wdata_i <= head.cfg_value;
              nxt_we       = 1'b1;
              // no request can be taken at the write edge, so update now
              if (head.cfg_idx == knn_pkg::CFG_NEIGHBOURS) neighbours_cfg = head.cfg_value;
              else entries_cfg = head.cfg_value;
            end
            void'(step_plan.pop_front());
          end
        end
      end
      start    <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && done_o) begin
      if (verdicts_due.size() == 0) begin
        $error("result strobe with no classify request outstanding");
        error_count++;
      end else begin
        want = verdicts_due.pop_front();
        if (predicted_class_o !== want.cls) begin
          $error("predicted_class: expected %0d, got %0d", want.cls, predicted_class_o);
          error_count++;
        end
        if (class_one_votes_o !== want.votes) begin
          $error("class_one_votes: expected %0d, got %0d", want.votes, class_one_votes_o);
          error_count++;
        end
        if (nearest_distance_o !== want.near_dist) begin
          $error("nearest_distance: expected %0d, got %0d", want.near_dist,
                 nearest_distance_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result stops the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || cfg_we_i) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Plan, reset, end of run
  // ---------------------------------------------------------------------------
  initial begin
    feat_vec_t vec;
    int unsigned style;
    logic calm;

    // Fill every slot first so no classify ever reads an unwritten entry.
    // Slots 2 and 3 share their features with opposite labels: distance tie.
    add_request(knn_pkg::FUNC_LOAD, 3'd0,
                vec4(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0, 1'b0);
    add_request(knn_pkg::FUNC_LOAD, 3'd1,
                vec4(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, 1'b0);
    add_request(knn_pkg::FUNC_LOAD, 3'd2,
                vec4(16'h1234, 16'h8000, 16'h00FF, 16'hAAAA), 1'b1, 1'b0);
    add_request(knn_pkg::FUNC_LOAD, 3'd3,
                vec4(16'h1234, 16'h8000, 16'h00FF, 16'hAAAA), 1'b0, 1'b0);
    add_request(knn_pkg::FUNC_LOAD, 3'd4,
                vec4(16'h5555, 16'hFFFF, 16'h0001, 16'h7FFF), 1'b1, 1'b0);
    add_request(knn_pkg::FUNC_LOAD, 3'd5,
                vec4(16'h0100, 16'h0200, 16'h0300, 16'h0400), 1'b1, 1'b0);
    add_request(knn_pkg::FUNC_LOAD, 3'd6,
                vec4(16'hFFFE, 16'h0001, 16'hC000, 16'h3FFF), 1'b0, 1'b0);
    add_request(knn_pkg::FUNC_LOAD, 3'd7,
                vec4(16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b1, 1'b0);
    // Reset settings: 3 voters over 6 entries.
    add_request(knn_pkg::FUNC_CLASSIFY, 3'd7,
                vec4(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, 1'b0);
    add_request(knn_pkg::FUNC_CLASSIFY, 3'd0,
                vec4(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, 1'b0);
    add_request(knn_pkg::FUNC_CLASSIFY, 3'd5,
                vec4(16'h1234, 16'h8000, 16'h00FF, 16'hAAAA), 1'b1, 1'b0);
    // Single voter: the tie must resolve to the label-0 entry.
    add_control(STEP_CONFIG, knn_pkg::CFG_NEIGHBOURS, 4'd1);
    add_control(STEP_CONFIG, knn_pkg::CFG_ENTRIES, 4'd8);
    add_request(knn_pkg::FUNC_CLASSIFY, 3'd2,
                vec4(16'h1234, 16'h8000, 16'h00FF, 16'hAAAA), 1'b0, 1'b0);
    add_request(knn_pkg::FUNC_CLASSIFY, 3'd6,
                vec4(16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b0, 1'b0);
    // Two voters split one to one: tied vote gives class 1.
    add_control(STEP_CONFIG, knn_pkg::CFG_NEIGHBOURS, 4'd2);
    add_request(knn_pkg::FUNC_CLASSIFY, 3'd3,
                vec4(16'h1234, 16'h8000, 16'h00FF, 16'hAAAA), 1'b0, 1'b0);
    // Zero in both registers acts as one; largest possible nearest distance.
    add_control(STEP_CONFIG, knn_pkg::CFG_NEIGHBOURS, 4'd0);
    add_control(STEP_CONFIG, knn_pkg::CFG_ENTRIES, 4'd0);
    add_request(knn_pkg::FUNC_CLASSIFY, 3'd1,
                vec4(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, 1'b0);
    // Above the table size: both act as 8.
    add_control(STEP_CONFIG, knn_pkg::CFG_NEIGHBOURS, 4'd15);
    add_control(STEP_CONFIG, knn_pkg::CFG_ENTRIES, 4'd15);
    add_request(knn_pkg::FUNC_CLASSIFY, 3'd4,
                vec4(16'h4000, 16'hC000, 16'h0010, 16'hFF00), 1'b0, 1'b0);
    add_request(knn_pkg::FUNC_CLASSIFY, 3'd0,
                vec4(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0, 1'b0);
    // More voters than entries in use: clamped to one.
    add_control(STEP_CONFIG, knn_pkg::CFG_NEIGHBOURS, 4'd8);
    add_control(STEP_CONFIG, knn_pkg::CFG_ENTRIES, 4'd1);
    add_request(knn_pkg::FUNC_CLASSIFY, 3'd2,
                vec4(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b0, 1'b0);

    // Random phases: fresh settings, then loads mixed with classifies.
    // Small value pools make distance ties and equal entries common.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      calm = (ph >= RAND_PHASES - 2);
      add_control(STEP_CONFIG, knn_pkg::CFG_NEIGHBOURS,
                  knn_pkg::CFG_W'($urandom_range(0, 15)));
      add_control(STEP_CONFIG, knn_pkg::CFG_ENTRIES,
                  knn_pkg::CFG_W'($urandom_range(0, 15)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off new requests until every result is back
        if (n == PHASE_ITEMS / 2 && ph % 3 == 0)
          add_control(STEP_DRAIN, knn_pkg::CFG_NEIGHBOURS, '0);
        style = $urandom_range(0, 2);
        for (int f = 0; f < knn_pkg::FEATURE_COUNT; f++) begin
          case (style)
            0: vec[f] = 16'($urandom_range(0, 65535));
            1: vec[f] = 16'($urandom_range(0, 3));
            default: begin
              case ($urandom_range(0, 2))
                0: vec[f] = 16'h0000;
                1: vec[f] = 16'hFFFF;
                default: vec[f] = 16'h8000;
              endcase
            end
          endcase
        end
        add_request(($urandom_range(0, 4) < 2) ? knn_pkg::FUNC_LOAD : knn_pkg::FUNC_CLASSIFY,
                    3'($urandom_range(0, 7)), vec, 1'($urandom_range(0, 1)), calm);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Everything presented, taken and answered, then a quiet stretch.
    do @(negedge clk_i);
    while (step_plan.size() != 0 || start || busy || verdicts_due.size() != 0 ||
           settle_cnt < SETTLE_CYCLES);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
